/* rtl/core/bpas_pkg.sv */
// shared types and constants of the branch penalty alignment score block
package bpas_pkg;

  localparam logic OP_TEMPLATE = 1'b0;
  localparam logic OP_QUERY    = 1'b1;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned PenW    = 6;
  localparam int unsigned BonusW  = 4;
  localparam int unsigned BaseW   = 8;
  localparam int unsigned ScoreW  = 11;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INSERT   = 3'd0,
    CFG_DELETE   = 3'd1,
    CFG_BRANCH   = 3'd2,
    CFG_MATCH    = 3'd3,
    CFG_MISMATCH = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [PenW-1:0] ins_pen;
    logic signed [PenW-1:0] del_pen;
    logic signed [PenW-1:0] br_pen;
    logic [BonusW-1:0]      mat_bonus;
    logic signed [PenW-1:0] mis_pen;
  } cfg_t;

  typedef struct packed {
    logic             is_query;
    logic [BaseW-1:0] base;
    logic             last;
  } item_t;

endpackage

/* rtl/core/bpas_front.sv */
// front end: accepts items, classifies them and queues them for the back end
module bpas_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        opcode_i,
  input  logic [bpas_pkg::BaseW-1:0]  base_i,
  input  logic                        last_i,
  output logic                        q_valid_o,
  output bpas_pkg::item_t             q_item_o,
  input  logic                        q_pop_i
);
  import bpas_pkg::*;

  item_t      slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       push;

  assign in_ready_o = (fill_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (fill_q != 2'd0);
  assign q_item_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{is_query: (opcode_i == OP_QUERY), base: base_i, last: last_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      if (push && !q_pop_i) begin
        fill_q <= fill_q + 2'd1;
      end else if (!push && q_pop_i) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

/* rtl/core/bpas_back.sv */
// back end: template store, column sweep over the score memory, result register
module bpas_back #(
  parameter int unsigned MAX_TEMPLATE = 128,
  parameter int unsigned MAX_QUERY    = 128
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  bpas_pkg::item_t              q_item_i,
  output logic                         q_pop_o,
  input  bpas_pkg::cfg_t               cfg_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [bpas_pkg::ScoreW-1:0]  peak_score_o
);
  import bpas_pkg::*;

  localparam int unsigned AW  = (MAX_TEMPLATE > 1) ? $clog2(MAX_TEMPLATE) : 1;
  localparam int unsigned CW  = $clog2(MAX_TEMPLATE + 1);
  localparam int unsigned QW  = $clog2(MAX_QUERY + 1);
  localparam int unsigned SW0 = $clog2(32 * (MAX_TEMPLATE + MAX_QUERY) + 1) + 1;
  localparam int unsigned SW  = (SW0 < 13) ? 13 : SW0;

  typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_EMIT} state_e;

  state_e                state_q;
  logic [CW-1:0]         tcount_q, iss_q;
  logic                  loading_q;
  logic [QW-1:0]         qpos_q;
  logic                  cmp_v_q;
  logic [AW-1:0]         cmp_k_q;
  logic                  first_q, adv_q, last_q;
  logic [BaseW-1:0]      qb_q;
  logic signed [SW-1:0]  diag_q, up_q, best_q;
  logic                  out_valid_q;
  logic [ScoreW-1:0]     out_q;

  logic [BaseW-1:0]      tmem [MAX_TEMPLATE];
  logic signed [SW-1:0]  smem [MAX_TEMPLATE];
  logic [BaseW-1:0]      t_rd_q, t_nx_q;
  logic signed [SW-1:0]  s_rd_q;

  logic                  issue, twr, branch, done, adv, emit;
  logic [AW-1:0]         twa, nxa;
  logic [CW-1:0]         k_plus1, iss_plus1;
  logic signed [SW-1:0]  old_v, ins_v, del_v, dia_v, v, cand;

  assign q_pop_o      = (state_q == ST_IDLE) && q_valid_i;
  assign out_valid_o  = out_valid_q;
  assign peak_score_o = out_q;

  assign issue     = (state_q == ST_SWEEP) && (iss_q < tcount_q);
  assign iss_plus1 = iss_q + CW'(1);
  assign nxa       = (iss_plus1 < tcount_q) ? iss_plus1[AW-1:0] : iss_q[AW-1:0];
  assign twr       = q_pop_o && !q_item_i.is_query
                     && (loading_q || (tcount_q < CW'(MAX_TEMPLATE)));
  assign twa       = loading_q ? '0 : tcount_q[AW-1:0];
  assign adv       = (qpos_q < QW'(MAX_QUERY));
  assign emit      = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  // one cell of the recurrence; first column of a query uses zero in place of the stored column
  always_comb begin
    k_plus1 = CW'(cmp_k_q) + CW'(1);
    old_v   = first_q ? '0 : s_rd_q;
    branch  = (k_plus1 < tcount_q) && (t_nx_q == t_rd_q);
    ins_v   = old_v + SW'(cfg_i.ins_pen);
    del_v   = up_q + (branch ? SW'(cfg_i.br_pen) : SW'(cfg_i.del_pen));
    dia_v   = diag_q + ((qb_q == t_rd_q) ? SW'($signed({1'b0, cfg_i.mat_bonus}))
                                         : SW'(cfg_i.mis_pen));
    v = ins_v;
    if (del_v > v) v = del_v;
    if (dia_v > v) v = dia_v;
    cand = adv_q ? v : old_v;
    done = cmp_v_q && (k_plus1 == tcount_q);
  end

  always_ff @(posedge clk_i) begin
    if (twr) tmem[twa] <= q_item_i.base;
    if (issue) begin
      t_rd_q <= tmem[iss_q[AW-1:0]];
      t_nx_q <= tmem[nxa];
      s_rd_q <= smem[iss_q[AW-1:0]];
    end
    if (cmp_v_q && adv_q) smem[cmp_k_q] <= v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tcount_q    <= '0;
      loading_q   <= 1'b1;
      qpos_q      <= '0;
      iss_q       <= '0;
      cmp_v_q     <= 1'b0;
      cmp_k_q     <= '0;
      first_q     <= 1'b0;
      adv_q       <= 1'b0;
      last_q      <= 1'b0;
      qb_q        <= '0;
      diag_q      <= '0;
      up_q        <= '0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      cmp_v_q <= issue;
      if (issue) begin
        iss_q   <= iss_plus1;
        cmp_k_q <= iss_q[AW-1:0];
      end
      if (emit) begin
        out_valid_q <= 1'b1;
        out_q       <= (best_q > SW'(2047)) ? ScoreW'(2047) : best_q[ScoreW-1:0];
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            if (!q_item_i.is_query) begin
              if (loading_q) begin
                tcount_q <= CW'(1);
              end else if (tcount_q < CW'(MAX_TEMPLATE)) begin
                tcount_q <= tcount_q + CW'(1);
              end
              loading_q <= q_item_i.last;
              qpos_q    <= '0;
            end else begin
              first_q <= (qpos_q == '0);
              adv_q   <= adv;
              last_q  <= q_item_i.last;
              qb_q    <= q_item_i.base;
              diag_q  <= '0;
              up_q    <= '0;
              best_q  <= '0;
              iss_q   <= '0;
              if (q_item_i.last) begin
                qpos_q <= '0;
              end else if (adv) begin
                qpos_q <= qpos_q + QW'(1);
              end
              if (tcount_q == '0) begin
                state_q <= q_item_i.last ? ST_EMIT : ST_IDLE;
              end else if (adv || q_item_i.last) begin
                state_q <= ST_SWEEP;
              end
            end
          end
        end
        ST_SWEEP: begin
          if (cmp_v_q) begin
            diag_q <= old_v;
            up_q   <= v;
            if (cand > best_q) best_q <= cand;
            if (done) state_q <= last_q ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (emit) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/branch_penalty_alignment_score.sv */
// top level: configuration registers, front queue and sweep back end
//
//  channel | signals                                  | direction
//  in      | in_valid_i in_ready_o opcode_i base_i last_i | item in
//  out     | out_valid_o out_ready_i peak_score_o     | result out
//  cfg     | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i | register write
//
// a template item is written to the template store as it is popped; a query item sweeps
// the template, one cell per cycle through the score column memory port, and, when it
// carries the last mark, then loads the result register
// a two-entry queue keeps taking items while the back end sweeps or a result waits
// reset clears control state and loads default scores; memories need no clearing
module branch_penalty_alignment_score #(
  parameter int unsigned MAX_TEMPLATE = 128,
  parameter int unsigned MAX_QUERY    = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [bpas_pkg::BaseW-1:0]    base_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bpas_pkg::ScoreW-1:0]   peak_score_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bpas_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bpas_pkg::PenW-1:0]     cfg_data_i
);
  import bpas_pkg::*;

  cfg_t  cfg_q;
  item_t q_item;
  logic  q_valid, q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ins_pen   <= -6'sd7;
      cfg_q.del_pen   <= -6'sd7;
      cfg_q.br_pen    <= -6'sd4;
      cfg_q.mat_bonus <= 4'd4;
      cfg_q.mis_pen   <= -6'sd13;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_INSERT:   cfg_q.ins_pen   <= cfg_data_i;
        CFG_DELETE:   cfg_q.del_pen   <= cfg_data_i;
        CFG_BRANCH:   cfg_q.br_pen    <= cfg_data_i;
        CFG_MATCH:    cfg_q.mat_bonus <= cfg_data_i[BonusW-1:0];
        CFG_MISMATCH: cfg_q.mis_pen   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bpas_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .base_i     (base_i),
    .last_i     (last_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  bpas_back #(
    .MAX_TEMPLATE (MAX_TEMPLATE),
    .MAX_QUERY    (MAX_QUERY)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .cfg_i        (cfg_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .peak_score_o (peak_score_o)
  );

endmodule
